FILE: rtl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants for the point-in-polygon ray-cast block.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int MAX_VERTICES_DEF = 256;
  localparam int COORD_BITS_DEF   = 32;

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FEW  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
  } in_item_t;

  typedef struct packed {
    logic       inside_res;
    logic [1:0] status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_FETCH,
    S_EDGE,
    S_CLOSE,
    S_M0,
    S_M1,
    S_M2,
    S_M3,
    S_M4,
    S_RESP
  } state_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_SUB,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    logic    mul_en;
    acc_op_t op;
  } mac_ctl_t;

endpackage

FILE: rtl/point_in_polygon_ray_cast.sv
// ----------------------------------------------------------------------------
// point_in_polygon_ray_cast
// Polygon vertex store with ray-cast point containment queries.
//
//   channel | dir | handshake        | payload
//   in_     | in  | in_valid/stall   | in_item_t  (kind, coord_x, coord_y)
//   out_    | out | out_valid/stall  | out_item_t (inside_res, status)
//
// A query walks every stored edge; each edge that straddles the ray line takes
// three products in the one shared multiply-accumulate.
// Synchronous reset clears vertex count and max |x|; the store is not cleared.
// A result waits in the output register; the next item is taken meanwhile.
// ----------------------------------------------------------------------------
module point_in_polygon_ray_cast #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = pip_pkg::COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pip_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pip_pkg::out_item_t out_data
);
  import pip_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int VW = 2 * COORD_BITS;
  localparam int DW = COORD_BITS + 2;

  logic                 busy, res_valid, res_ready;
  out_item_t            res;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr, rd_addr;
  logic [VW-1:0]        wr_data, rd_data;
  mac_ctl_t             mac_ctl;
  logic signed [DW-1:0] mac_a, mac_b;
  logic                 acc_zero, acc_neg;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r;

  assign in_stall  = busy;
  assign res_ready = !out_valid_r || !out_stall;

  pip_ctrl #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid),
    .item       (in_data),
    .busy       (busy),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .mac_ctl    (mac_ctl),
    .mac_a      (mac_a),
    .mac_b      (mac_b),
    .acc_zero   (acc_zero),
    .acc_neg    (acc_neg)
  );

  pip_vstore #(
    .DEPTH (MAX_VERTICES),
    .AW    (AW),
    .DW    (VW)
  ) u_vstore (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pip_mac #(
    .DW (DW)
  ) u_mac (
    .clk      (clk),
    .ctl      (mac_ctl),
    .op_a     (mac_a),
    .op_b     (mac_b),
    .acc_zero (acc_zero),
    .acc_neg  (acc_neg)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/pip_vstore.sv
// ----------------------------------------------------------------------------
// pip_vstore
// Vertex memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pip_vstore #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 64
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/pip_mac.sv
// ----------------------------------------------------------------------------
// pip_mac
// Shared signed multiply-accumulate used for the edge orientation terms.
// ----------------------------------------------------------------------------
module pip_mac #(
  parameter int DW = 34
) (
  input  logic                 clk,
  input  pip_pkg::mac_ctl_t    ctl,
  input  logic signed [DW-1:0] op_a,
  input  logic signed [DW-1:0] op_b,
  output logic                 acc_zero,
  output logic                 acc_neg
);
  import pip_pkg::*;

  localparam int PW = 2 * DW;

  logic signed [PW-1:0] prod_r, prod_nxt;
  logic signed [PW:0]   acc_r, acc_nxt;
  logic signed [PW:0]   prod_ext;

  assign prod_nxt = op_a * op_b;
  assign prod_ext = {prod_r[PW-1], prod_r};

  always_comb begin
    case (ctl.op)
      ACC_LOAD: acc_nxt = prod_ext;
      ACC_SUB:  acc_nxt = acc_r - prod_ext;
      ACC_ADD:  acc_nxt = acc_r + prod_ext;
      default:  acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= prod_nxt;
    end
    acc_r <= acc_nxt;
  end

  assign acc_zero = (acc_r == '0);
  assign acc_neg  = acc_r[PW];

endmodule

FILE: rtl/pip_ctrl.sv
// ----------------------------------------------------------------------------
// pip_ctrl
// Sequencer: vertex bookkeeping, edge walk and orientation steps per query.
// ----------------------------------------------------------------------------
module pip_ctrl #(
  parameter int MAX_VERTICES = 256,
  parameter int COORD_BITS   = 32,
  localparam int CW = $clog2(MAX_VERTICES + 1),
  localparam int AW = $clog2(MAX_VERTICES),
  localparam int VW = 2 * COORD_BITS,
  localparam int DW = COORD_BITS + 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  pip_pkg::in_item_t    item,
  output logic                 busy,
  output logic                 res_valid,
  output pip_pkg::out_item_t   res,
  input  logic                 res_ready,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output logic [VW-1:0]        wr_data,
  output logic [AW-1:0]        rd_addr,
  input  logic [VW-1:0]        rd_data,
  output pip_pkg::mac_ctl_t    mac_ctl,
  output logic signed [DW-1:0] mac_a,
  output logic signed [DW-1:0] mac_b,
  input  logic                 acc_zero,
  input  logic                 acc_neg
);
  import pip_pkg::*;

  localparam int CB = COORD_BITS;

  state_t                state_r, state_nxt;
  logic [1:0]            kind_r, kind_nxt;
  logic [CB-1:0]         px_r, px_nxt, py_r, py_nxt;
  logic [CW-1:0]         count_r, count_nxt, idx_r, idx_nxt;
  logic [CB-1:0]         max_r, max_nxt;
  logic [CB:0]           rx_r, rx_nxt;
  logic [VW-1:0]         first_r, first_nxt, prev_r, prev_nxt;
  logic [VW-1:0]         ea_r, ea_nxt, eb_r, eb_nxt;
  logic                  last_r, last_nxt, parity_r, parity_nxt;
  logic                  o3z_r, o3z_nxt, o3n_r, o3n_nxt;
  out_item_t             res_r, res_nxt;

  logic [CB:0]           px_ext, mag_full;
  logic [CB-1:0]         mag_px;
  logic [VW-1:0]         tst_a, tst_b;
  logic                  a_lt, a_eq, b_lt, b_eq, rx_ne, ray_hit, hit;
  logic signed [DW-1:0]  ax, ay, bx, by, pxe, pye, rxe;

  assign px_ext   = {px_r[CB-1], px_r};
  assign mag_full = px_r[CB-1] ? (~px_ext + 1'b1) : px_ext;
  assign mag_px   = mag_full[CB-1:0];

  // ray-side test: edge end points on different sides of the ray line
  assign tst_a   = prev_r;
  assign tst_b   = (state_r == S_CLOSE) ? first_r : rd_data;
  assign a_lt    = $signed(tst_a[VW-1:CB]) < $signed(py_r);
  assign a_eq    = tst_a[VW-1:CB] == py_r;
  assign b_lt    = $signed(tst_b[VW-1:CB]) < $signed(py_r);
  assign b_eq    = tst_b[VW-1:CB] == py_r;
  assign rx_ne   = rx_r != px_ext;
  assign ray_hit = rx_ne && ((a_lt != b_lt) || (a_eq != b_eq));

  assign ax  = {{2{ea_r[CB-1]}}, ea_r[CB-1:0]};
  assign ay  = {{2{ea_r[VW-1]}}, ea_r[VW-1:CB]};
  assign bx  = {{2{eb_r[CB-1]}}, eb_r[CB-1:0]};
  assign by  = {{2{eb_r[VW-1]}}, eb_r[VW-1:CB]};
  assign pxe = {{2{px_r[CB-1]}}, px_r};
  assign pye = {{2{py_r[CB-1]}}, py_r};
  assign rxe = {1'b0, rx_r};

  assign hit = (acc_zero != o3z_r) || (acc_neg != o3n_r);

  assign busy      = (state_r != S_IDLE);
  assign res       = res_r;
  assign rd_addr   = idx_r[AW-1:0];

  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    max_nxt    = max_r;
    rx_nxt     = rx_r;
    first_nxt  = first_r;
    prev_nxt   = prev_r;
    ea_nxt     = ea_r;
    eb_nxt     = eb_r;
    last_nxt   = last_r;
    parity_nxt = parity_r;
    o3z_nxt    = o3z_r;
    o3n_nxt    = o3n_r;
    res_nxt    = res_r;
    res_valid  = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = count_r[AW-1:0];
    wr_data    = {py_r, px_r};
    mac_ctl    = '{mul_en: 1'b0, op: ACC_HOLD};
    mac_a      = '0;
    mac_b      = '0;

    case (state_r)
      S_IDLE: begin
        if (item_valid) begin
          kind_nxt  = item.kind;
          px_nxt    = item.coord_x[CB-1:0];
          py_nxt    = item.coord_y[CB-1:0];
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (kind_r)
          KIND_CLEAR: begin
            count_nxt = '0;
            max_nxt   = '0;
            state_nxt = S_IDLE;
          end
          KIND_APPEND: begin
            res_nxt.inside_res = 1'b0;
            if (count_r == CW'(MAX_VERTICES)) begin
              res_nxt.status = ST_FULL;
            end else begin
              wr_en          = 1'b1;
              count_nxt      = count_r + 1'b1;
              res_nxt.status = ST_OK;
              if (mag_px > max_r) begin
                max_nxt = mag_px;
              end
            end
            state_nxt = S_RESP;
          end
          KIND_QUERY: begin
            if (count_r < CW'(3)) begin
              res_nxt.inside_res = 1'b0;
              res_nxt.status     = ST_FEW;
              state_nxt          = S_RESP;
            end else begin
              idx_nxt    = '0;
              parity_nxt = 1'b0;
              last_nxt   = 1'b0;
              rx_nxt     = {1'b0, max_r} + 1'b1;
              state_nxt  = S_FETCH;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_FETCH: begin
        state_nxt = S_EDGE;
      end
      S_EDGE: begin
        prev_nxt = rd_data;
        idx_nxt  = idx_r + 1'b1;
        if (idx_r == '0) begin
          first_nxt = rd_data;
          state_nxt = S_FETCH;
        end else if (ray_hit) begin
          ea_nxt    = prev_r;
          eb_nxt    = rd_data;
          state_nxt = S_M0;
        end else if (idx_r + 1'b1 == count_r) begin
          state_nxt = S_CLOSE;
        end else begin
          state_nxt = S_FETCH;
        end
      end
      S_CLOSE: begin
        last_nxt = 1'b1;
        if (ray_hit) begin
          ea_nxt    = prev_r;
          eb_nxt    = first_r;
          state_nxt = S_M0;
        end else begin
          res_nxt.inside_res = parity_r;
          res_nxt.status     = ST_OK;
          state_nxt          = S_RESP;
        end
      end
      // o3 = (py-ay)(bx-px) - (px-ax)(by-py); o4 = o3 + (rx-px)(ay-by)
      S_M0: begin
        mac_ctl   = '{mul_en: 1'b1, op: ACC_HOLD};
        mac_a     = pye - ay;
        mac_b     = bx - pxe;
        state_nxt = S_M1;
      end
      S_M1: begin
        mac_ctl   = '{mul_en: 1'b1, op: ACC_LOAD};
        mac_a     = pxe - ax;
        mac_b     = by - pye;
        state_nxt = S_M2;
      end
      S_M2: begin
        mac_ctl   = '{mul_en: 1'b1, op: ACC_SUB};
        mac_a     = rxe - pxe;
        mac_b     = ay - by;
        state_nxt = S_M3;
      end
      S_M3: begin
        mac_ctl   = '{mul_en: 1'b0, op: ACC_ADD};
        o3z_nxt   = acc_zero;
        o3n_nxt   = acc_neg;
        state_nxt = S_M4;
      end
      S_M4: begin
        parity_nxt = parity_r ^ hit;
        if (last_r) begin
          res_nxt.inside_res = parity_r ^ hit;
          res_nxt.status     = ST_OK;
          state_nxt          = S_RESP;
        end else if (idx_r == count_r) begin
          state_nxt = S_CLOSE;
        end else begin
          state_nxt = S_FETCH;
        end
      end
      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      max_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      max_r   <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    px_r     <= px_nxt;
    py_r     <= py_nxt;
    idx_r    <= idx_nxt;
    rx_r     <= rx_nxt;
    first_r  <= first_nxt;
    prev_r   <= prev_nxt;
    ea_r     <= ea_nxt;
    eb_r     <= eb_nxt;
    last_r   <= last_nxt;
    parity_r <= parity_nxt;
    o3z_r    <= o3z_nxt;
    o3n_r    <= o3n_nxt;
    res_r    <= res_nxt;
  end

endmodule

FILE: rtl/pip_chk.sv
// ----------------------------------------------------------------------------
// pip_chk
// Port-level checks for the point-in-polygon block, bound to the top level.
// ----------------------------------------------------------------------------
module pip_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input pip_pkg::out_item_t out_data
);
  import pip_pkg::*;

  // held result must not change under stall
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item at a time: busy right after an input transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous item in progress");

  // no result appears from an idle block with an empty output
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !in_stall |=> !out_valid)
    else $error("result without an input transfer");

  // error statuses never report inside
  a_status_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK) ||
                  (out_data.status == ST_FEW && !out_data.inside_res) ||
                  (out_data.status == ST_FULL && !out_data.inside_res))
    else $error("bad status or inside flag on error");

endmodule

bind point_in_polygon_ray_cast pip_chk u_pip_chk (.*);
